// ----- src/olid_pkg.sv -----
// ============================================================================
// olid_pkg: shared types for the ordered list unit
// Operation and status codes, word layouts and the controller states.
// ============================================================================
package olid_pkg;

    // operation codes; the spare code behaves as a query
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    // command word
    typedef struct packed {
        logic [1:0]         operation;
        logic [10:0]        position;
        logic signed [31:0] value;
    } t_olid_cmd;

    // result word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [9:0]         max_index;
        logic signed [31:0] max_value;
        logic [10:0]        count;
        logic               empty_res;
    } t_olid_res;

endpackage

// ----- src/olid_stream_if.sv -----
// ============================================================================
// olid_stream_if: valid/ready stream carrying one word
// The source drives valid and data, the sink drives ready.
// ============================================================================
interface olid_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/ordered_list_insert_delete_max_unit.sv -----
// ============================================================================
// ordered_list_insert_delete_max_unit: positional list with max report
// Insert, delete and query on a list of signed words held in one RAM.
// Each command is one pass over the list that shifts entries and tracks
// the first largest entry at the same time.
// ============================================================================
//
//   channel  dir  word        handshake
//   i_cmd    in   t_olid_cmd  valid/ready, taken in idle state
//   o_res    out  t_olid_res  valid/ready, one word per command
//
// A command makes n RAM reads in its pass: count + 1 for insert, count
// for delete and query, so at most CAPACITY. The single RAM read port
// reads one entry per cycle. A pass that reads nothing (query or
// rejected command on an empty list) goes straight to the result state.
// Reset clears the count; the RAM needs no clearing, entries past the
// count are never used. A new command is taken while a result still
// waits; the pass then stalls at its end until the output register is
// free.
//
module ordered_list_insert_delete_max_unit
    import olid_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    olid_stream_if.sink   i_cmd,
    olid_stream_if.source o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 11) ? CW : 11) + 1;

    // control registers
    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic    r_issue, n_issue;
    logic    r_dv, n_dv;
    logic    r_have, n_have;
    logic    r_out_valid, n_out_valid;

    // payload registers
    t_op     r_op, n_op;
    t_status r_status, n_status;
    logic [AW-1:0] r_q, n_q;
    logic [AW-1:0] r_last, n_last;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_d, n_d;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_hold, n_hold;
    logic signed [31:0] r_removed, n_removed;
    logic signed [31:0] r_best, n_best;
    t_olid_res r_out, n_out;

    // ram ports
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   rd_data;

    // datapath helpers
    logic signed [31:0] rdata;
    logic signed [31:0] ne;
    logic [AW-1:0]      k;
    logic               step_en;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      idx_x;
    logic               out_free;

    assign rdata = signed'(rd_data);
    assign pos_x = XW'(i_cmd.data.position);
    assign cnt_x = XW'(r_count);
    assign idx_x = XW'(r_best_idx);

    // list storage
    olid_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (ne),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    // new element at step k: delete lags one word behind the read stream
    always_comb begin
        k       = (r_op == OP_DELETE) ? r_d - AW'(1) : r_d;
        step_en = r_dv && !(r_op == OP_DELETE && r_d == '0);
        case (r_op)
            OP_INSERT: begin
                if (k < r_q) begin
                    ne = rdata;
                end else if (k == r_q) begin
                    ne = r_val;
                end else begin
                    ne = r_hold;
                end
            end
            OP_DELETE: begin
                ne = (k < r_q) ? r_hold : rdata;
            end
            default: begin
                ne = rdata;
            end
        endcase
        wr_en   = step_en && (r_op != OP_QUERY) && (k >= r_q);
        wr_addr = k;
        rd_en   = (r_state == S_RUN) && r_issue;
    end

    assign out_free = !r_out_valid || o_res.ready;

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_dv        = rd_en;
        n_have      = r_have;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_status    = r_status;
        n_q         = r_q;
        n_last      = r_last;
        n_rd_addr   = r_rd_addr;
        n_d         = r_rd_addr;
        n_best_idx  = r_best_idx;
        n_val       = r_val;
        n_hold      = r_dv ? rdata : r_hold;
        n_removed   = r_removed;
        n_best      = r_best;
        n_out       = r_out;

        // result handed off
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    // decode the command against the current count
                    n_val      = i_cmd.data.value;
                    n_q        = AW'(pos_x - XW'(1));
                    n_rd_addr  = '0;
                    n_issue    = 1'b1;
                    n_have     = 1'b0;
                    n_removed  = '0;
                    n_best     = '0;
                    n_best_idx = '0;
                    n_status   = ST_OK;
                    n_op       = OP_QUERY;
                    n_last     = AW'(r_count - CW'(1));
                    case (i_cmd.data.operation)
                        OP_INSERT: begin
                            if (cnt_x == XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                                n_status = ST_ILLEGAL;
                            end else begin
                                n_op    = OP_INSERT;
                                n_last  = AW'(r_count);
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_ILLEGAL;
                            end else begin
                                n_op    = OP_DELETE;
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_op = OP_QUERY;
                        end
                    endcase
                    // a query-like pass over an empty list reads nothing
                    if (n_op == OP_QUERY && r_count == '0) begin
                        n_issue = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                // read issue
                if (r_issue) begin
                    if (r_rd_addr == r_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end
                // capture the removed word
                if (r_dv && r_op == OP_DELETE && r_d == r_q) begin
                    n_removed = rdata;
                end
                // running maximum, first one wins on ties
                if (step_en && (!r_have || ne > r_best)) begin
                    n_best     = ne;
                    n_best_idx = k;
                    n_have     = 1'b1;
                end
                if (r_dv && r_d == r_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.status        = r_status;
                    n_out.removed_value = r_removed;
                    n_out.max_index     = idx_x[9:0];
                    n_out.max_value     = r_best;
                    n_out.count         = cnt_x[10:0];
                    n_out.empty_res     = (r_count == '0);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_dv        <= n_dv;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_status   <= n_status;
        r_q        <= n_q;
        r_last     <= n_last;
        r_rd_addr  <= n_rd_addr;
        r_d        <= n_d;
        r_best_idx <= n_best_idx;
        r_val      <= n_val;
        r_hold     <= n_hold;
        r_removed  <= n_removed;
        r_best     <= n_best;
        r_out      <= n_out;
    end

    // channel ports
    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

// ----- src/olid_ram.sv -----
// ============================================================================
// olid_ram: simple dual-port RAM
// One write port and one read port, read data registered (read-first).
// ============================================================================
module olid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- test/ordered_list_insert_delete_max_unit_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ordered_list_insert_delete_max_unit_test: list unit self-checking bench
// Drives insert, delete and query words through the command stream and
// checks every result word against a shadow copy of the list. A directed
// opening covers the empty list, the extremes, ties and bad positions.
// Three random phases with changing stalls follow, then a short tail of
// far positions and edits at both ends.
// ============================================================================
module ordered_list_insert_delete_max_unit_test;
    import olid_pkg::*;

    localparam int          LIST_DEPTH = 1024;
    localparam int          SOFT_FILL  = 40;
    localparam int          PHASE_LEN  = 193;
    localparam logic [1:0]  OP_SPARE   = 2'd3;
    localparam logic [31:0] WORD_MAX   = 32'h7fff_ffff;
    localparam logic [31:0] WORD_MIN   = 32'h8000_0000;

    // shadow list and the queue of result words still owed
    class list_scoreboard;
        logic signed [31:0] shadow_list [LIST_DEPTH];
        int unsigned        shadow_count;
        t_olid_res          owed_res [$];
        int unsigned        errors;

        function new();
            shadow_count = 0;
            errors       = 0;
        endfunction

        function int unsigned pending();
            return owed_res.size();
        endfunction

        // apply one accepted command word and queue the result it owes
        function void note_cmd(t_olid_cmd c);
            t_olid_res          r;
            int unsigned        p;
            int                 k;
            logic signed [31:0] best;
            r = '0;
            p = c.position;
            r.status = ST_OK;
            case (c.operation)
                OP_INSERT: begin
                    if (shadow_count >= LIST_DEPTH) begin
                        r.status = ST_FULL;
                    end else if (p < 1 || p > shadow_count + 1) begin
                        r.status = ST_ILLEGAL;
                    end else begin
                        for (k = shadow_count; k >= p; k--)
                            shadow_list[k] = shadow_list[k - 1];
                        shadow_list[p - 1] = c.value;
                        shadow_count++;
                    end
                end
                OP_DELETE: begin
                    if (p < 1 || p > shadow_count) begin
                        r.status = ST_ILLEGAL;
                    end else begin
                        r.removed_value = shadow_list[p - 1];
                        for (k = p; k < shadow_count; k++)
                            shadow_list[k - 1] = shadow_list[k];
                        shadow_count--;
                    end
                end
                default: begin
                end
            endcase
            // first largest entry wins on ties
            if (shadow_count > 0) begin
                best = shadow_list[0];
                for (k = 1; k < shadow_count; k++) begin
                    if (shadow_list[k] > best) begin
                        best        = shadow_list[k];
                        r.max_index = 10'(k);
                    end
                end
                r.max_value = best;
            end
            r.count     = 11'(shadow_count);
            r.empty_res = (shadow_count == 0);
            owed_res.push_back(r);
        endfunction

        function void match(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result word with the oldest one owed
        function void check_res(t_olid_res got);
            t_olid_res want;
            if (owed_res.size() == 0) begin
                $error("result word arrived with none owed");
                errors++;
                return;
            end
            want = owed_res.pop_front();
            match("status", want.status, got.status);
            match("removed_value", $signed(want.removed_value), $signed(got.removed_value));
            match("max_index", want.max_index, got.max_index);
            match("max_value", $signed(want.max_value), $signed(got.max_value));
            match("count", want.count, got.count);
            match("empty_res", want.empty_res, got.empty_res);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;

    list_scoreboard sb = new();

    olid_stream_if #(.T(t_olid_cmd)) cmd_if ();
    olid_stream_if #(.T(t_olid_res)) res_if ();

    ordered_list_insert_delete_max_unit #(
        .CAPACITY (LIST_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // result side: check accepted words, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_res(res_if.data);
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic t_olid_cmd make_cmd(logic [1:0] op, int pos, logic [31:0] val);
        t_olid_cmd c;
        c.operation = op;
        c.position  = 11'(pos);
        c.value     = val;
        return c;
    endfunction

    // values biased toward ties and the signed extremes
    function automatic logic [31:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return $urandom_range(4) - 2;
        else if (pick == 3)
            return $urandom_range(1) ? WORD_MAX : WORD_MIN;
        return $urandom();
    endfunction

    // mostly legal positions on a short list, some bad ones
    function automatic t_olid_cmd rand_cmd();
        int unsigned n;
        int unsigned sel;
        int unsigned pos;
        logic [1:0]  op;
        n   = sb.shadow_count;
        sel = $urandom_range(99);
        if (sel < 5)
            op = OP_SPARE;
        else if (sel < 14)
            op = OP_QUERY;
        else if ($urandom_range(99) < ((n >= SOFT_FILL) ? 30 : 60))
            op = OP_INSERT;
        else
            op = OP_DELETE;
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(2))
                0: pos = 0;
                1: pos = (op == OP_INSERT) ? n + 2 : n + 1;
                default: pos = $urandom_range(2047);
            endcase
        end else if (op == OP_INSERT) begin
            pos = $urandom_range(n + 1, 1);
        end else begin
            pos = (n == 0) ? $urandom_range(2047) : $urandom_range(n, 1);
        end
        return make_cmd(op, pos, rand_value());
    endfunction

    // present one command word, hold it until taken; valid stays high after
    task automatic send_cmd(t_olid_cmd c);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        sb.note_cmd(c);
    endtask

    // drop valid and hold off until every owed word is back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        cmd_if.valid  <= 1'b0;
        cmd_if.data   <= '0;
        i_rst_n       <= 1'b0;
        src_idle_pct  = 9;
        sink_idle_pct = 58;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, spare code, bad positions
        send_cmd(make_cmd(OP_QUERY, 0, 32'd0));
        send_cmd(make_cmd(OP_DELETE, 1, 32'd0));
        send_cmd(make_cmd(OP_SPARE, 5, 32'hdead_beef));
        send_cmd(make_cmd(OP_INSERT, 0, 32'd7));
        send_cmd(make_cmd(OP_INSERT, 2, 32'd7));
        // extremes and a tie for largest
        send_cmd(make_cmd(OP_INSERT, 1, WORD_MAX));
        send_cmd(make_cmd(OP_INSERT, 1, WORD_MIN));
        send_cmd(make_cmd(OP_INSERT, 3, WORD_MAX));
        send_cmd(make_cmd(OP_INSERT, 2, -1));
        send_cmd(make_cmd(OP_QUERY, 2047, WORD_MIN));
        send_cmd(make_cmd(OP_DELETE, 0, 32'd0));
        send_cmd(make_cmd(OP_DELETE, sb.shadow_count + 1, 32'd0));
        send_cmd(make_cmd(OP_DELETE, 2047, 32'd0));
        send_cmd(make_cmd(OP_INSERT, 2047, 32'd0));
        send_cmd(make_cmd(OP_INSERT, sb.shadow_count + 2, 32'd0));
        // remove the first of the tied entries, then the tail, then the head
        send_cmd(make_cmd(OP_DELETE, 3, 32'd0));
        send_cmd(make_cmd(OP_DELETE, sb.shadow_count, 32'd0));
        send_cmd(make_cmd(OP_DELETE, 1, 32'd0));
        send_cmd(make_cmd(OP_SPARE, 0, 32'd0));
        send_cmd(make_cmd(OP_DELETE, 1, 32'd0));
        send_cmd(make_cmd(OP_INSERT, 1, 32'd0));
        send_cmd(make_cmd(OP_INSERT, 1, -5));
        send_cmd(make_cmd(OP_DELETE, 2, 32'd0));
        send_cmd(make_cmd(OP_DELETE, 1, 32'd0));

        // random, receiver stalls often
        repeat (PHASE_LEN) send_cmd(rand_cmd());
        wait_drained();

        // random, sender idles often
        src_idle_pct  = 58;
        sink_idle_pct = 9;
        repeat (PHASE_LEN) send_cmd(rand_cmd());

        // random, no stalls on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (PHASE_LEN) send_cmd(rand_cmd());

        // far positions, then edits at both ends
        send_cmd(make_cmd(OP_INSERT, 1, WORD_MAX));
        send_cmd(make_cmd(OP_INSERT, 0, 32'd1));
        send_cmd(make_cmd(OP_INSERT, 2047, 32'd1));
        send_cmd(make_cmd(OP_QUERY, 0, 32'd0));
        send_cmd(make_cmd(OP_DELETE, LIST_DEPTH + 1, 32'd0));
        send_cmd(make_cmd(OP_DELETE, LIST_DEPTH, 32'd0));
        send_cmd(make_cmd(OP_INSERT, LIST_DEPTH + 1, 32'd3));
        send_cmd(make_cmd(OP_INSERT, LIST_DEPTH, WORD_MAX));
        send_cmd(make_cmd(OP_DELETE, 1, 32'd0));
        send_cmd(make_cmd(OP_INSERT, 1, WORD_MIN));
        send_cmd(make_cmd(OP_SPARE, 0, 32'd0));
        wait_drained();

        repeat (LIST_DEPTH + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ordered_list_insert_delete_max_unit verification clean");
        else
            $display("ordered_list_insert_delete_max_unit verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("ordered_list_insert_delete_max_unit verification failed");
        $finish;
    end

endmodule
